### sv/pss_pkg.sv
package pss_pkg;

	localparam int STAT_W = 48;
	localparam logic [STAT_W-1:0] STAT_MAX = '1;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic [1:0] REG_TOTAL_CASES   = 2'd0;
	localparam logic [1:0] REG_MINIMUM_CASES = 2'd1;
	localparam logic [1:0] REG_PENALTY_EN    = 2'd2;
	localparam logic [1:0] REG_MAX_ONLY      = 2'd3;

	typedef struct packed {
		logic [23:0]        case_count;
		logic [23:0]        total_cases;
		logic [23:0]        minimum_cases;
		logic signed [23:0] log_expected_in;
		logic signed [23:0] log_expected_out;
		logic [16:0]        penalty;
		logic               penalty_enable;
	} req_t;

	typedef struct packed {
		logic              idle;
		logic              done;
		logic [STAT_W-1:0] stat;
	} res_t;

endpackage

### sv/pss_mul.sv
module pss_mul (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	assign p = 64'(a) * 64'(b);

endmodule

### sv/pss_core.sv
module pss_core #(
	parameter int FRACTION_BITS = 16,
	parameter int COUNT_BITS    = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pss_pkg::req_t req,
	input  logic          ack,
	output pss_pkg::res_t res
);

	localparam int FB   = FRACTION_BITS;
	localparam int LGW  = FB + 5;
	localparam int LW   = ((LGW > 24) ? LGW : 24) + 2;
	localparam int AW   = 32 + LW + 2;
	localparam int NCH  = (AW - 1 + 31) / 32;
	localparam int UPW  = NCH * 32;
	localparam int SW   = UPW + FB;
	localparam int IW   = $clog2(FB + 1);
	localparam logic [31:0] CMASK = 32'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [31:0] ONE = 32'(64'd1 << FB);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NORM = 4'd1;
	localparam logic [3:0] S_SQ   = 4'd2;
	localparam logic [3:0] S_LN   = 4'd3;
	localparam logic [3:0] S_PIN  = 4'd4;
	localparam logic [3:0] S_POUT = 4'd5;
	localparam logic [3:0] S_CHK  = 4'd6;
	localparam logic [3:0] S_PEN  = 4'd7;
	localparam logic [3:0] S_SAT  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]              state_q;
	logic [IW-1:0]           cnt_q;
	logic                    sel_q;
	logic [31:0]             m_q;
	logic [LGW-1:0]          lg_q;
	logic [31:0]             yin_q;
	logic [31:0]             yout_q;
	logic signed [23:0]      lei_q;
	logic signed [23:0]      leo_q;
	logic [16:0]             pen_q;
	logic                    pen_en_q;
	logic signed [LW-1:0]    lrin_q;
	logic signed [LW-1:0]    lrout_q;
	logic signed [AW-1:0]    acc_q;
	logic [UPW-1:0]          u_q;
	logic [SW-1:0]           sum_q;
	logic [pss_pkg::STAT_W-1:0] stat_q;

	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [63:0]             prod;
	logic [31:0]             yin_w;
	logic [31:0]             ty_w;
	logic                    zero_case;
	logic [5:0]              sh;
	logic                    hi_zero;
	logic [32:0]             sq;
	logic [64:0]             lnsum;
	logic signed [LGW:0]     ln_s;
	logic signed [LW-1:0]    lr;
	logic signed [AW-1:0]    pm;
	logic [31:0]             mag_in;
	logic [31:0]             mag_out;
	logic [UPW-1:0]          vpen;

	pss_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (prod)
	);

	assign yin_w     = 32'(req.case_count) & CMASK;
	assign ty_w      = 32'(req.total_cases) & CMASK;
	assign zero_case = (yin_w < 32'(req.minimum_cases)) || (yin_w == '0) || (ty_w < yin_w);

	assign sh      = 6'd16 >> cnt_q;
	assign hi_zero = (m_q >> (6'd32 - sh)) == '0;
	assign sq      = prod[63:31];
	assign lnsum   = 65'(prod) + 65'(64'd1 << 31);
	assign ln_s    = signed'({1'b0, lnsum[32+LGW-1:32]});
	assign lr      = LW'(ln_s) - LW'(sel_q ? leo_q : lei_q);
	assign mag_in  = lrin_q[LW-1] ? 32'(-lrin_q) : 32'(lrin_q);
	assign mag_out = lrout_q[LW-1] ? 32'(-lrout_q) : 32'(lrout_q);
	assign pm      = signed'(AW'(prod));
	assign vpen    = UPW'(sum_q >> FB);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			S_LN: begin
				mul_a = 32'(lg_q);
				mul_b = pss_pkg::LN2_Q32;
			end
			S_PIN: begin
				mul_a = yin_q;
				mul_b = mag_in;
			end
			S_POUT: begin
				mul_a = yout_q;
				mul_b = mag_out;
			end
			S_PEN: begin
				mul_a = u_q[UPW-1 -: 32];
				mul_b = 32'(pen_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				yin_q    <= yin_w;
				yout_q   <= ty_w - yin_w;
				lei_q    <= req.log_expected_in;
				leo_q    <= req.log_expected_out;
				pen_q    <= req.penalty;
				pen_en_q <= req.penalty_enable;
				m_q      <= yin_w;
				lg_q     <= LGW'(31);
				stat_q   <= '0;
			end
			S_NORM: begin
				if (hi_zero) begin
					m_q  <= m_q << sh;
					lg_q <= lg_q - LGW'(sh);
				end
			end
			S_SQ: begin
				m_q  <= sq[32] ? sq[32:1] : sq[31:0];
				lg_q <= {lg_q[LGW-2:0], sq[32]};
			end
			S_LN: begin
				if (!sel_q) begin
					lrin_q <= lr;
				end else begin
					lrout_q <= lr;
				end
				if (lrin_q <= lr) begin
					stat_q <= '0;
				end
				m_q  <= yout_q;
				lg_q <= LGW'(31);
			end
			S_PIN: begin
				acc_q <= lrin_q[LW-1] ? -pm : pm;
			end
			S_POUT: begin
				acc_q <= acc_q + (lrout_q[LW-1] ? -pm : pm);
			end
			S_CHK: begin
				u_q   <= UPW'(acc_q);
				sum_q <= '0;
				if (acc_q[AW-1] || acc_q == '0) begin
					stat_q <= '0;
				end else if (acc_q > AW'(pss_pkg::STAT_MAX)) begin
					stat_q <= pss_pkg::STAT_MAX;
				end else begin
					stat_q <= acc_q[pss_pkg::STAT_W-1:0];
				end
			end
			S_PEN: begin
				sum_q <= (sum_q << 32) + SW'(prod);
				u_q   <= u_q << 32;
			end
			S_SAT: begin
				stat_q <= (vpen > UPW'(pss_pkg::STAT_MAX)) ? pss_pkg::STAT_MAX
					: vpen[pss_pkg::STAT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					sel_q <= 1'b0;
					if (start) begin
						state_q <= zero_case ? S_DONE : S_NORM;
					end
				end
				S_NORM: begin
					if (cnt_q == IW'(4)) begin
						cnt_q   <= '0;
						state_q <= S_SQ;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQ: begin
					if (cnt_q == IW'(FB - 1)) begin
						cnt_q   <= '0;
						state_q <= S_LN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_LN: begin
					if (!sel_q) begin
						if (yout_q == '0) begin
							state_q <= S_PIN;
						end else begin
							sel_q   <= 1'b1;
							state_q <= S_NORM;
						end
					end else begin
						state_q <= (lrin_q <= lr) ? S_DONE : S_PIN;
					end
				end
				S_PIN: begin
					state_q <= (yout_q == '0) ? S_CHK : S_POUT;
				end
				S_POUT: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (acc_q[AW-1] || acc_q == '0) begin
						state_q <= S_DONE;
					end else if (pen_en_q && 32'(pen_q) < ONE) begin
						cnt_q   <= '0;
						state_q <= S_PEN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PEN: begin
					if (cnt_q == IW'(NCH - 1)) begin
						state_q <= S_SAT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SAT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.idle = (state_q == S_IDLE);
	assign res.done = (state_q == S_DONE);
	assign res.stat = stat_q;

endmodule

### sv/poisson_scan_statistic_top.sv
// channel   handshake             payload
// in        in_valid / in_stall   case_count, log_expected_in, log_expected_out, penalty,
//                                 last_zone
// out       out_valid / out_stall statistic, is_maximum, last_result
// config    APB psel/penable      paddr, pwdata, prdata
//
// A request runs through up to two logs, the products and the penalty chunks from accept to
// next accept; a zone rejected on its counts goes from accept straight to the done state.
// All of it runs through one shared 32x32 multiplier under the core sequencer.
// in_stall is high while a request is in the core; a result waits in the output
// register while out_stall is high and the core holds its finished request.
// Reset clears the configuration registers (minimum cases resets to 1), running maximum and control state.
module poisson_scan_statistic_top #(
	parameter int FRACTION_BITS = 16,
	parameter int COUNT_BITS    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] case_count,
	input  logic signed [23:0] log_expected_in,
	input  logic signed [23:0] log_expected_out,
	input  logic [16:0] penalty,
	input  logic        last_zone,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [47:0] statistic,
	output logic        is_maximum,
	output logic        last_result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [23:0]   total_q;
	logic [23:0]   minc_q;
	logic          pen_en_q;
	logic          max_only_q;
	logic [47:0]   rmax_q;
	logic          last_q;
	logic          out_valid_q;
	logic [47:0]   stat_q;
	logic          is_max_q;
	logic          last_res_q;

	pss_pkg::req_t req;
	pss_pkg::res_t res;
	logic          start;
	logic          emit;
	logic          ack;
	logic [47:0]   new_max;
	logic          wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			pss_pkg::REG_TOTAL_CASES:   prdata = 32'(total_q);
			pss_pkg::REG_MINIMUM_CASES: prdata = 32'(minc_q);
			pss_pkg::REG_PENALTY_EN:    prdata = 32'(pen_en_q);
			pss_pkg::REG_MAX_ONLY:      prdata = 32'(max_only_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			minc_q     <= 24'd1;
			pen_en_q   <= 1'b0;
			max_only_q <= 1'b0;
		end else if (wr) begin
			unique case (paddr[3:2])
				pss_pkg::REG_TOTAL_CASES:   total_q    <= pwdata[23:0];
				pss_pkg::REG_MINIMUM_CASES: minc_q     <= pwdata[23:0];
				pss_pkg::REG_PENALTY_EN:    pen_en_q   <= pwdata[0];
				pss_pkg::REG_MAX_ONLY:      max_only_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = !res.idle;
	assign start    = in_valid && !in_stall;

	assign req.case_count       = case_count;
	assign req.total_cases      = total_q;
	assign req.minimum_cases    = minc_q;
	assign req.log_expected_in  = log_expected_in;
	assign req.log_expected_out = log_expected_out;
	assign req.penalty          = penalty;
	assign req.penalty_enable   = pen_en_q;

	pss_core #(
		.FRACTION_BITS (FRACTION_BITS),
		.COUNT_BITS    (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.ack    (ack),
		.res    (res)
	);

	assign new_max = (res.stat > rmax_q) ? res.stat : rmax_q;
	assign emit    = !max_only_q || last_q;
	assign ack     = res.done && (!emit || !out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (start) begin
			last_q <= last_zone;
		end
		if (ack && emit) begin
			stat_q     <= max_only_q ? new_max : res.stat;
			is_max_q   <= max_only_q;
			last_res_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmax_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ack) begin
				if (last_q) begin
					rmax_q <= '0;
				end else if (max_only_q) begin
					rmax_q <= new_max;
				end
			end
			if (ack && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign statistic   = stat_q;
	assign is_maximum  = is_max_q;
	assign last_result = last_res_q;

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("core idle after a request was taken");

	a_max_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_maximum |-> last_result)
		else $error("batch maximum sent before the last zone");

	a_out_from_core: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(res.done))
		else $error("output raised without a finished request");

endmodule

### dv/poisson_scan_statistic_top_test.sv
`timescale 1ns / 1ps

typedef struct {
	logic [47:0] statistic;
	logic        is_maximum;
	logic        last_result;
} zone_result_t;

class zone_scoreboard;
	logic [23:0]  total_cases = 24'd0;
	logic [23:0]  minimum_cases = 24'd1;
	logic         penalty_enable = 1'b0;
	logic         max_only = 1'b0;
	logic [47:0]  batch_max = 48'd0;
	zone_result_t expected_results[$];
	int           errors = 0;

	function void write_reg(logic [1:0] idx, logic [31:0] value);
		case (idx)
			pss_pkg::REG_TOTAL_CASES: begin
				total_cases = value[23:0];
			end
			pss_pkg::REG_MINIMUM_CASES: begin
				minimum_cases = value[23:0];
			end
			pss_pkg::REG_PENALTY_EN: begin
				penalty_enable = value[0];
			end
			default: begin
				max_only = value[0];
			end
		endcase
	endfunction

	function longint log_q16(logic [31:0] x);
		int          lead;
		logic [63:0] m;
		logic [63:0] log2v;
		lead = 0;
		if (x == 0)
			return 0;
		for (int i = 0; i < 32; i++)
			if (x[i])
				lead = i;
		m = 64'(x) << (31 - lead);
		log2v = 64'(lead);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			log2v = log2v << 1;
			if (m >= (64'd1 << 32)) begin
				log2v[0] = 1'b1;
				m = m >> 1;
			end
		end
		log2v = (log2v * 64'(pss_pkg::LN2_Q32) + (64'd1 << 31)) >> 32;
		return longint'(log2v);
	endfunction

	function logic [47:0] zone_score(logic [23:0] cases_in, logic signed [23:0] log_in,
			logic signed [23:0] log_out, logic [16:0] penalty);
		longint      cases_out;
		longint      lr_in;
		longint      lr_out;
		longint      t;
		logic [63:0] u;
		if (cases_in < minimum_cases || cases_in == 0 || total_cases < cases_in)
			return 48'd0;
		cases_out = longint'(total_cases) - longint'(cases_in);
		lr_in = log_q16(32'(cases_in)) - longint'(log_in);
		if (cases_out == 0) begin
			t = longint'(cases_in) * lr_in;
		end else begin
			lr_out = log_q16(32'(cases_out)) - longint'(log_out);
			if (lr_in <= lr_out)
				return 48'd0;
			t = longint'(cases_in) * lr_in + cases_out * lr_out;
		end
		if (t <= 0)
			return 48'd0;
		u = 64'(t);
		if (penalty_enable && penalty < 17'h10000)
			u = (u >> 16) * 64'(penalty) + ((64'(u[15:0]) * 64'(penalty)) >> 16);
		if (u > 64'(pss_pkg::STAT_MAX))
			u = 64'(pss_pkg::STAT_MAX);
		return u[47:0];
	endfunction

	function void note_request(logic [23:0] cases_in, logic signed [23:0] log_in,
			logic signed [23:0] log_out, logic [16:0] penalty, logic last_zone);
		logic [47:0]  s;
		zone_result_t r;
		s = zone_score(cases_in, log_in, log_out, penalty);
		if (!max_only) begin
			if (last_zone)
				batch_max = 48'd0;
			r.statistic = s;
			r.is_maximum = 1'b0;
			r.last_result = last_zone;
			expected_results.push_back(r);
		end else begin
			if (s > batch_max)
				batch_max = s;
			if (last_zone) begin
				r.statistic = batch_max;
				r.is_maximum = 1'b1;
				r.last_result = 1'b1;
				expected_results.push_back(r);
				batch_max = 48'd0;
			end
		end
	endfunction

	function void check_result(logic [47:0] statistic, logic is_maximum, logic last_result);
		zone_result_t r;
		if (expected_results.size() == 0) begin
			$error("unexpected result statistic=%0h", statistic);
			errors++;
			return;
		end
		r = expected_results.pop_front();
		if (statistic !== r.statistic) begin
			$error("statistic expected %0h actual %0h", r.statistic, statistic);
			errors++;
		end
		if (is_maximum !== r.is_maximum) begin
			$error("is_maximum expected %0b actual %0b", r.is_maximum, is_maximum);
			errors++;
		end
		if (last_result !== r.last_result) begin
			$error("last_result expected %0b actual %0b", r.last_result, last_result);
			errors++;
		end
	endfunction
endclass

module poisson_scan_statistic_top_test;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [23:0]        case_count;
	logic signed [23:0] log_expected_in;
	logic signed [23:0] log_expected_out;
	logic [16:0]        penalty;
	logic               last_zone;
	logic               out_valid;
	logic               out_stall;
	logic [47:0]        statistic;
	logic               is_maximum;
	logic               last_result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	zone_scoreboard zones;
	int             send_idle_pct;
	int             recv_stall_pct;
	bit             hold_request;
	int             hold_left;

	poisson_scan_statistic_top DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			zones.check_result(statistic, is_maximum, last_result);

	task write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		zones.write_reg(idx, value);
	endtask

	task send_zone(input logic [23:0] cc, input logic signed [23:0] lin,
			input logic signed [23:0] lout, input logic [16:0] pen, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		case_count <= cc;
		log_expected_in <= lin;
		log_expected_out <= lout;
		penalty <= pen;
		last_zone <= last;
		do
			@(posedge clk);
		while (in_stall);
		zones.note_request(cc, lin, lout, pen, last);
	endtask

	task drain;
		in_valid <= 1'b0;
		while (zones.expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task configure(input logic [23:0] total, input logic [23:0] minimum,
			input logic pen_en, input logic max_mode);
		write_reg(pss_pkg::REG_TOTAL_CASES, {8'd0, total});
		write_reg(pss_pkg::REG_MINIMUM_CASES, {8'd0, minimum});
		write_reg(pss_pkg::REG_PENALTY_EN, {31'd0, pen_en});
		write_reg(pss_pkg::REG_MAX_ONLY, {31'd0, max_mode});
	endtask

	task send_random_zone(input int last_one_in);
		logic [23:0]        cc;
		logic signed [23:0] lin;
		logic signed [23:0] lout;
		logic [16:0]        pen;
		if ($urandom_range(9) < 7 && zones.total_cases != 0)
			cc = 24'($urandom_range(zones.total_cases, 1));
		else
			cc = 24'($urandom);
		if ($urandom_range(9) < 7) begin
			lin = 24'($signed($urandom_range(2097152)) - 1048576);
			lout = 24'($signed($urandom_range(2097152)) - 1048576);
		end else begin
			lin = 24'($urandom);
			lout = 24'($urandom);
		end
		pen = ($urandom_range(9) < 6) ? 17'($urandom_range(65535)) : 17'($urandom);
		send_zone(cc, lin, lout, pen, ($urandom_range(last_one_in - 1) == 0));
	endtask

	initial begin
		logic [23:0] total;
		logic [23:0] minimum;
		zones = new;
		arst_n = 1'b0;
		in_valid = 1'b0;
		case_count = '0;
		log_expected_in = '0;
		log_expected_out = '0;
		penalty = '0;
		last_zone = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 33;
		recv_stall_pct = 57;
		hold_request = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(24'd1000, 24'd5, 1'b1, 1'b0);
		send_zone(24'd0, 24'sd0, 24'sd0, 17'd0, 1'b0);
		send_zone(24'd3, 24'sd0, 24'sd0, 17'd65536, 1'b0);
		send_zone(24'd2000, 24'sd0, 24'sd0, 17'd65536, 1'b0);
		send_zone(24'hFFFFFF, 24'sh7FFFFF, 24'sh800000, 17'h1FFFF, 1'b0);
		send_zone(24'd1000, 24'sd100000, 24'sd0, 17'd65536, 1'b0);
		send_zone(24'd1000, 24'sh7FFFFF, 24'sd0, 17'd65536, 1'b0);
		send_zone(24'd100, 24'sd500000, 24'sh800000, 17'd65536, 1'b0);
		send_zone(24'd100, 24'sh800000, 24'sh7FFFFF, 17'd0, 1'b0);
		send_zone(24'd100, 24'sh800000, 24'sh7FFFFF, 17'd65535, 1'b0);
		send_zone(24'd100, 24'sh800000, 24'sh7FFFFF, 17'h1FFFF, 1'b0);
		send_zone(24'd500, 24'sh800000, 24'sd0, 17'd32768, 1'b1);
		drain;
		configure(24'hFFFFFF, 24'd0, 1'b0, 1'b1);
		send_zone(24'hFFFFFF, 24'sh800000, 24'sh7FFFFF, 17'd0, 1'b0);
		send_zone(24'd8388608, 24'sh800000, 24'sh800000, 17'd0, 1'b0);
		send_zone(24'd1, 24'sh800000, 24'sh7FFFFF, 17'd0, 1'b1);
		send_zone(24'd1, 24'sh800000, 24'sh7FFFFF, 17'd0, 1'b1);
		drain;
		configure(24'd0, 24'hFFFFFF, 1'b1, 1'b0);
		send_zone(24'd0, 24'sd0, 24'sd0, 17'd0, 1'b1);
		send_zone(24'hFFFFFF, 24'sd0, 24'sd0, 17'd0, 1'b1);
		drain;

		for (int p = 0; p < 12; p++) begin
			case (p / 4)
				0: begin
					send_idle_pct = 33;
					recv_stall_pct = 57;
				end
				1: begin
					send_idle_pct = 57;
					recv_stall_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			case ($urandom_range(4))
				0: total = 24'd1;
				1: total = 24'hFFFFFF;
				2: total = 24'($urandom_range(200, 2));
				default: total = 24'($urandom);
			endcase
			case ($urandom_range(5))
				0: minimum = 24'd0;
				1: minimum = 24'hFFFFFF;
				2: minimum = 24'd1;
				default: minimum = 24'($urandom_range(20));
			endcase
			configure(total, minimum, p[0], p[1]);
			if (p == 0 || p == 8)
				hold_request = 1'b1;
			for (int n = 0; n < 96; n++) begin
				if (p == 5 && n == 48) begin
					in_valid <= 1'b0;
					while (zones.expected_results.size() != 0)
						@(posedge clk);
				end
				send_random_zone(p[1] ? 8 : 10);
			end
			send_random_zone(1);
			drain;
		end

		if (zones.errors == 0 && zones.expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
